[design/swmm_pkg.sv]
`default_nettype none

package swmm_pkg;

	localparam int DATA_W           = 32;
	localparam int WINDOW_LEN_W     = 11;
	localparam int COUNT_W          = 24;
	localparam int APB_AW           = 3;
	localparam int MAX_WINDOW_DEF   = 1024;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

	// register index, taken from paddr[2]
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     last_in;
	} swmm_req_t;

	typedef struct packed {
		logic                     window_valid;
		logic signed [DATA_W-1:0] window_min;
		logic signed [DATA_W-1:0] window_max;
		logic                     span_match;
		logic [COUNT_W-1:0]       match_count;
		logic                     last_out;
	} swmm_res_t;

endpackage

`default_nettype wire

[design/swmm_hist_ram.sv]
`default_nettype none

module swmm_hist_ram #(
	parameter int DEPTH = swmm_pkg::MAX_WINDOW_DEF,
	parameter int WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/sliding_window_min_max_span.sv]
// Sliding-window min/max with span test. Each request carries one signed sample; once
// window_len samples of the current sequence have arrived, the result gives the minimum and
// maximum of the last window_len samples, a flag set when max - min equals window_len - 1,
// and a saturating count of flagged windows. last_in closes the sequence: the result is sent,
// then the fill level and count clear. Samples sit in a single-port-read history RAM; each
// request writes its sample and, once the window is full, reads back the window_len - 1
// older samples, one per cycle. A new request is taken while the previous result still waits
// on res_stall. window_len is written through the APB port at byte address 0; the user must
// write it only while no request is in flight, which the block itself does not enforce.
`default_nettype none

module sliding_window_min_max_span #(
	parameter int MAX_WINDOW   = swmm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swmm_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [swmm_pkg::APB_AW-1:0]    paddr,
	input  wire logic [swmm_pkg::DATA_W-1:0]    pwdata,
	output logic      [swmm_pkg::DATA_W-1:0]    prdata,
	output logic                                pready,

	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire swmm_pkg::swmm_req_t            req_data,

	output logic                                res_valid,
	input  wire logic                           res_stall,
	output swmm_pkg::swmm_res_t                 res_data
);

	localparam int AW    = $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (LEN_W > swmm_pkg::WINDOW_LEN_W) ? LEN_W : swmm_pkg::WINDOW_LEN_W;
	localparam int DW    = ((SAMPLE_WIDTH + 1 > LEN_W + 1) ? SAMPLE_WIDTH + 1 : LEN_W + 1) + 1;
	localparam logic signed [DW-1:0] SPAN_ONE = DW'(1);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		DONE
	} state_t;

	state_t state_q;

	logic [swmm_pkg::WINDOW_LEN_W-1:0] window_len_q;
	logic [AW-1:0]                     wr_ptr_q;
	logic [AW-1:0]                     rd_ptr_q;
	logic [LEN_W-1:0]                  fill_q;
	logic [LEN_W-1:0]                  len_q;
	logic [LEN_W-1:0]                  issue_left_q;
	logic                              rvalid_s1;
	logic                              win_valid_q;
	logic                              last_q;
	logic signed [SAMPLE_WIDTH-1:0]    lo_q;
	logic signed [SAMPLE_WIDTH-1:0]    hi_q;
	logic [swmm_pkg::COUNT_W-1:0]      count_q;
	logic                              res_valid_q;
	swmm_pkg::swmm_res_t               res_q;

	logic                              accept;
	logic                              cfg_wr;
	logic                              rd_en;
	logic signed [SAMPLE_WIDTH-1:0]    sample_c;
	logic signed [SAMPLE_WIDTH-1:0]    rdata;
	logic [CMP_W-1:0]                  wl_c;
	logic [LEN_W-1:0]                  eff_len_c;
	logic [LEN_W-1:0]                  fill_next_c;
	logic                              full_c;
	logic [AW-1:0]                     prev_ptr_c;
	logic [AW-1:0]                     rd_prev_c;
	logic [AW-1:0]                     wr_next_c;
	logic                              out_free;
	logic signed [DW-1:0]              span_c;
	logic signed [DW-1:0]              len_w_c;
	logic                              match_c;
	logic [swmm_pkg::COUNT_W-1:0]      count_next_c;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == swmm_pkg::REG_WINDOW_LEN);

	always_comb begin
		prdata = '0;
		if (paddr[2] == swmm_pkg::REG_WINDOW_LEN) begin
			prdata = swmm_pkg::DATA_W'(window_len_q);
		end
	end

	assign req_stall = (state_q != IDLE);
	assign accept    = req_valid && !req_stall;
	assign sample_c  = req_data.sample[SAMPLE_WIDTH-1:0];

	always_comb begin
		wl_c = CMP_W'(window_len_q);
		if (wl_c == '0) begin
			eff_len_c = LEN_W'(1);
		end else if (wl_c > CMP_W'(MAX_WINDOW)) begin
			eff_len_c = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len_c = LEN_W'(wl_c);
		end
	end

	assign fill_next_c = (fill_q < LEN_W'(MAX_WINDOW)) ? fill_q + LEN_W'(1) : fill_q;
	assign full_c      = (fill_next_c >= eff_len_c);
	assign prev_ptr_c  = (wr_ptr_q == '0) ? AW'(MAX_WINDOW - 1) : wr_ptr_q - AW'(1);
	assign rd_prev_c   = (rd_ptr_q == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr_q - AW'(1);
	assign wr_next_c   = (wr_ptr_q == AW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_q + AW'(1);
	assign rd_en       = (state_q == SCAN) && (issue_left_q != '0);

	// reads start the cycle after the write, so they never collide with it
	swmm_hist_ram #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (SAMPLE_WIDTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (accept),
		.waddr (wr_ptr_q),
		.wdata (sample_c),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	assign out_free = !res_valid_q || !res_stall;
	assign span_c   = DW'(hi_q) - DW'(lo_q) + SPAN_ONE;
	assign len_w_c  = signed'(DW'(len_q));
	assign match_c  = win_valid_q && (span_c == len_w_c);
	assign count_next_c = (match_c && (count_q != swmm_pkg::COUNT_TOP))
		? count_q + swmm_pkg::COUNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			window_len_q <= swmm_pkg::WINDOW_LEN_W'(1);
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			fill_q       <= '0;
			len_q        <= '0;
			issue_left_q <= '0;
			rvalid_s1    <= 1'b0;
			win_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			lo_q         <= '0;
			hi_q         <= '0;
			count_q      <= '0;
			res_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (cfg_wr) begin
				window_len_q <= pwdata[swmm_pkg::WINDOW_LEN_W-1:0];
			end
			if (res_valid_q && !res_stall && (state_q != DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					rvalid_s1 <= 1'b0;
					if (accept) begin
						wr_ptr_q     <= wr_next_c;
						rd_ptr_q     <= prev_ptr_c;
						fill_q       <= fill_next_c;
						len_q        <= eff_len_c;
						win_valid_q  <= full_c;
						issue_left_q <= full_c ? eff_len_c - LEN_W'(1) : '0;
						last_q       <= req_data.last_in;
						lo_q         <= sample_c;
						hi_q         <= sample_c;
						state_q      <= SCAN;
					end
				end
				SCAN: begin
					rvalid_s1 <= rd_en;
					if (rd_en) begin
						rd_ptr_q     <= rd_prev_c;
						issue_left_q <= issue_left_q - LEN_W'(1);
					end
					if (rvalid_s1) begin
						if (rdata < lo_q) begin
							lo_q <= rdata;
						end
						if (rdata > hi_q) begin
							hi_q <= rdata;
						end
					end
					if (issue_left_q == '0) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					rvalid_s1 <= 1'b0;
					if (out_free) begin
						res_valid_q             <= 1'b1;
						res_q.window_valid      <= win_valid_q;
						res_q.window_min        <= win_valid_q ? swmm_pkg::DATA_W'(lo_q) : '0;
						res_q.window_max        <= win_valid_q ? swmm_pkg::DATA_W'(hi_q) : '0;
						res_q.span_match        <= match_c;
						res_q.match_count       <= count_next_c;
						res_q.last_out          <= last_q;
						if (last_q) begin
							fill_q  <= '0;
							count_q <= '0;
						end else begin
							count_q <= count_next_c;
						end
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire
